### rtl/core/rmsp_pkg.sv
package rmsp_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CfgW = 16;
  localparam int unsigned IdxW = 10;

  // Depth of the mean-square store; a power of two no larger than the index range.
  localparam int unsigned ParamCount = 1024;

  // Configuration register indexes.
  localparam logic [1:0] CFG_LEARNING_RATE = 2'd0;
  localparam logic [1:0] CFG_DISCOUNT = 2'd1;
  localparam logic [1:0] CFG_EPSILON = 2'd2;

  localparam logic [CfgW-1:0] LrReset = 16'd655;
  localparam logic [CfgW-1:0] DiscountReset = 16'd58982;
  localparam logic [CfgW-1:0] EpsilonReset = 16'd1;
  localparam logic [DataW-1:0] MeanSquareOne = 32'h0001_0000;

  // Request handed from the main sequencer to the root/divide unit.
  typedef struct packed {
    logic [47:0] radicand;
    logic [47:0] numer;
    logic [15:0] eps;
  } div_req_t;

endpackage

### rtl/core/rmsp_root_div.sv
// Computes floor(numer / (floor(sqrt(radicand)) + eps)), with a zero divisor taken as one.
// The root is found two radicand bits per cycle, the quotient one bit per cycle.
module rmsp_root_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  rmsp_pkg::div_req_t  req,
  output logic                done,
  output logic [47:0]         quotient
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ROOT = 2'd1;
  localparam logic [1:0] ST_DIV = 2'd2;

  logic [1:0]  state_r, state_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [47:0] rad_r, rad_nxt;
  logic [24:0] rem_r, rem_nxt;
  logic [23:0] root_r, root_nxt;
  logic [47:0] num_r, num_nxt;
  logic [15:0] eps_r, eps_nxt;
  logic [32:0] den_r, den_nxt;
  logic [47:0] drem_r, drem_nxt;
  logic [47:0] quo_r, quo_nxt;
  logic        done_r, done_nxt;

  logic [26:0] trial;
  logic [26:0] rem_sh;
  logic        take;
  logic [23:0] root_new;
  logic [32:0] den_sum;
  logic [48:0] drem_sh;

  assign rem_sh = {rem_r, rad_r[47:46]};
  assign trial = {1'b0, root_r, 2'b01};
  assign take = (rem_sh >= trial);
  assign root_new = {root_r[22:0], take};
  assign den_sum = {9'd0, root_new} + {17'd0, eps_r};
  assign drem_sh = {drem_r, num_r[47]};

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    rad_nxt = rad_r;
    rem_nxt = rem_r;
    root_nxt = root_r;
    num_nxt = num_r;
    eps_nxt = eps_r;
    den_nxt = den_r;
    drem_nxt = drem_r;
    quo_nxt = quo_r;
    done_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_ROOT;
          cnt_nxt = 6'd0;
          rad_nxt = req.radicand;
          rem_nxt = '0;
          root_nxt = '0;
          num_nxt = req.numer;
          eps_nxt = req.eps;
        end
      end
      ST_ROOT: begin
        if (take) begin
          rem_nxt = 25'(rem_sh - trial);
        end else begin
          rem_nxt = rem_sh[24:0];
        end
        root_nxt = root_new;
        rad_nxt = {rad_r[45:0], 2'b00};
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd23) begin
          state_nxt = ST_DIV;
          cnt_nxt = 6'd0;
          den_nxt = (den_sum == 33'd0) ? 33'd1 : den_sum;
          drem_nxt = '0;
        end
      end
      ST_DIV: begin
        if (drem_sh >= {16'd0, den_r}) begin
          drem_nxt = 48'(drem_sh - {16'd0, den_r});
          quo_nxt = {quo_r[46:0], 1'b1};
        end else begin
          drem_nxt = drem_sh[47:0];
          quo_nxt = {quo_r[46:0], 1'b0};
        end
        num_nxt = {num_r[46:0], 1'b0};
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd47) begin
          state_nxt = ST_IDLE;
          done_nxt = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      done_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rad_r <= rad_nxt;
    rem_r <= rem_nxt;
    root_r <= root_nxt;
    num_r <= num_nxt;
    eps_r <= eps_nxt;
    den_r <= den_nxt;
    drem_r <= drem_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quotient = quo_r;

endmodule

### rtl/core/rmsprop_weight_update_unit.sv
// RMSprop weight update engine.
// Input requests on in_* carry a parameter index, its gradient and its current
// weight. The block reads that entry's mean square from an internal memory, forms
// m' = d*m + (1-d)*g^2 (saturated), writes m' back, and returns
// w' = w - lr*g / (sqrt(m') + eps) on out_* with the index and a saturation flag.
// Configuration is written through cfg_we/cfg_index/cfg_wdata while idle; the user
// must keep to this, as the block does not enforce it. One request is processed at a
// time. After a request is accepted, the block reads the entry and forms the products,
// the shared root/divide unit finds the square root and does the bit-serial division,
// and the result is handed over, which raises out_tvalid. A new request is accepted only
// after the previous one has been handed to the output register.
// After reset the block first sweeps the mean-square memory to 1.0, one entry per
// cycle, with in_tready low; configuration writes are taken.
// The result sits in an output register until out_tready is high. Meanwhile the
// next request is accepted and processed; it waits in its last step until the
// output register is free, so a stalled receiver holds the block.
module rmsprop_weight_update_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [9:0] param_index, [41:10] gradient, [73:42] weight, [79:74] zero
  input  logic [79:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [9:0] index_out, [41:10] new_weight, [47:42] zero
  output logic [47:0] out_tdata,
  // [0] saturated
  output logic        out_tuser,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int unsigned AddrW = $clog2(rmsp_pkg::ParamCount);
  localparam int unsigned CntW = $clog2(rmsp_pkg::ParamCount + 1);
  localparam logic [CntW-1:0] LastAddr = CntW'(rmsp_pkg::ParamCount - 1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_READ = 3'd2;
  localparam logic [2:0] ST_MUL = 3'd3;
  localparam logic [2:0] ST_ACC = 3'd4;
  localparam logic [2:0] ST_DIV = 3'd5;
  localparam logic [2:0] ST_OUT = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [CntW-1:0] clr_r, clr_nxt;

  logic [15:0] lr_r, disc_r, eps_r;

  logic [9:0]  idx_r;
  logic [31:0] mag_r;
  logic        neg_r;
  logic [31:0] w_r;
  logic [AddrW-1:0] addr_r;
  logic [63:0] g2full_r;
  logic [47:0] dm_r;
  logic [63:0] dg_r;
  logic [31:0] m_new;
  logic        m_ovf;
  logic [47:0] numer_r;

  logic [31:0] mem [rmsp_pkg::ParamCount];
  logic [31:0] rd_r;
  logic        mem_we;
  logic [AddrW-1:0] mem_wa;
  logic [31:0] mem_wd;

  logic        out_valid_r;
  logic [31:0] out_w_r;
  logic [9:0]  out_idx_r;
  logic        out_sat_r;
  logic        out_load;

  logic [9:0]  in_idx;
  logic [31:0] in_g, in_w;
  logic [31:0] in_mag;
  logic [AddrW-1:0] in_addr;

  logic [63:0] acc_sum;
  logic [47:0] m_full;
  logic [16:0] one_minus_d;

  logic        div_start, div_done;
  logic [47:0] div_q;
  rmsp_pkg::div_req_t div_req;

  logic        big_step;
  logic [33:0] nw;
  logic [31:0] nw_sat;
  logic        wsat;

  assign in_idx = in_tdata[9:0];
  assign in_g = in_tdata[41:10];
  assign in_w = in_tdata[73:42];
  assign in_mag = in_g[31] ? (32'd0 - in_g) : in_g;
  // The store depth is a power of two, so the low index bits select the entry.
  assign in_addr = in_idx[AddrW-1:0];

  assign in_tready = (state_r == ST_IDLE);
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_tready);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r <= rmsp_pkg::LrReset;
      disc_r <= rmsp_pkg::DiscountReset;
      eps_r <= rmsp_pkg::EpsilonReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rmsp_pkg::CFG_LEARNING_RATE: lr_r <= cfg_wdata;
        rmsp_pkg::CFG_DISCOUNT: disc_r <= cfg_wdata;
        rmsp_pkg::CFG_EPSILON: eps_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign one_minus_d = 17'h10000 - {1'b0, disc_r};
  assign acc_sum = {16'd0, dm_r} + dg_r;
  assign m_full = acc_sum[63:16];

  assign div_req.radicand = {m_new, 16'd0};
  assign div_req.numer = numer_r;
  assign div_req.eps = eps_r;
  assign div_start = (state_r == ST_ACC);

  rmsp_root_div u_root_div (
    .clk(clk),
    .rst_n(rst_n),
    .start(div_start),
    .req(div_req),
    .done(div_done),
    .quotient(div_q)
  );

  // A step of 2^32 or more always saturates; smaller steps fit a 34-bit signed sum.
  assign big_step = |div_q[47:32];
  assign nw = neg_r ? ({{2{w_r[31]}}, w_r} + {2'b0, div_q[31:0]})
                    : ({{2{w_r[31]}}, w_r} - {2'b0, div_q[31:0]});

  always_comb begin
    wsat = 1'b0;
    nw_sat = nw[31:0];
    if (big_step) begin
      wsat = 1'b1;
      nw_sat = neg_r ? 32'h7FFF_FFFF : 32'h8000_0000;
    end else if (!nw[33] && (nw[32] || nw[31])) begin
      wsat = 1'b1;
      nw_sat = 32'h7FFF_FFFF;
    end else if (nw[33] && !(nw[32] && nw[31])) begin
      wsat = 1'b1;
      nw_sat = 32'h8000_0000;
    end
  end

  always_comb begin
    state_nxt = state_r;
    clr_nxt = clr_r;
    mem_we = 1'b0;
    mem_wa = addr_r;
    mem_wd = m_new;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_r[AddrW-1:0];
        mem_wd = rmsp_pkg::MeanSquareOne;
        clr_nxt = clr_r + CntW'(1);
        if (clr_r == LastAddr) state_nxt = ST_IDLE;
      end
      ST_IDLE: if (in_tvalid && in_tready) state_nxt = ST_READ;
      ST_READ: state_nxt = ST_MUL;
      ST_MUL: state_nxt = ST_ACC;
      ST_ACC: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: if (div_done) state_nxt = ST_OUT;
      ST_OUT: if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
    if (state_r == ST_ACC) mem_we = 1'b1;
  end

  // Mean square store; ST_ACC writes the value computed in ST_MUL.
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_r <= mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
    if (state_r == ST_IDLE) begin
      idx_r <= in_idx;
      mag_r <= in_mag;
      neg_r <= in_g[31];
      w_r <= in_w;
      addr_r <= in_addr;
    end
    // ST_READ: memory output arrives next cycle; square the gradient now.
    if (state_r == ST_READ) begin
      g2full_r <= {32'd0, mag_r} * {32'd0, mag_r};
    end
    if (state_r == ST_MUL) begin
      dm_r <= {16'd0, disc_r} * {16'd0, rd_r};
      dg_r <= 64'(one_minus_d) * 64'(g2full_r[63:16]);
      numer_r <= {16'd0, lr_r} * {16'd0, mag_r};
    end
    if (out_load) begin
      out_w_r <= nw_sat;
      out_idx_r <= idx_r;
      out_sat_r <= wsat | m_ovf;
    end
  end

  // m' is formed combinationally from the registered products, which hold until
  // the result is handed over.
  always_comb begin
    if (|m_full[47:32]) begin
      m_new = 32'hFFFF_FFFF;
      m_ovf = 1'b1;
    end else begin
      m_new = m_full[31:0];
      m_ovf = 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {6'd0, out_w_r, out_idx_r};
  assign out_tuser = out_sat_r;

endmodule
